FILE: hdl/mstc_pkg.sv
// Package for the minimum spanning tree cost unit.
// Holds the transaction payload types, the edge store entry and the sequencer states.
// No dependencies.
package mstc_pkg;

  localparam int unsigned CFG_W = 5;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  typedef struct packed {
    logic [3:0]         src_vertex;
    logic [3:0]         dst_vertex;
    logic signed [15:0] weight;
    logic               last_edge;
  } in_t;

  typedef struct packed {
    logic signed [19:0] total_cost;
    logic [3:0]         edges_taken;
    logic               spanning;
    logic               overflow;
  } out_t;

  typedef struct packed {
    logic [3:0]         src;
    logic [3:0]         dst;
    logic signed [15:0] weight;
  } edge_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_CLR,
    S_SCAN,
    S_EVAL,
    S_FIND,
    S_FCHK,
    S_RKA,
    S_RKB,
    S_JOIN,
    S_OUT
  } state_e;

endpackage

FILE: hdl/minimum_spanning_tree_cost_unit.sv
// Minimum spanning tree cost unit: edge store, selection ordering, union-find by rank.
// Depends on mstc_pkg.
//
//  channel | direction | handshake       | payload
//  in      | input     | valid / stall   | mstc_pkg::in_t
//  out     | output    | valid / stall   | mstc_pkg::out_t
//  cfg     | input     | valid / ready   | vertex_count, 5 bits
//
// Edges load one per cycle. After the last edge the input stalls: the sequencer clears the
// union-find memories, then for each edge visited in weight order it scans the store, walks
// the parent path to each endpoint's root and, when the roots differ, joins them by rank;
// running out of edges costs one more scan, and the result is written once edges run out or
// the tree spans. Reset is async, active low. A result waits in the output register while
// loading resumes; a second result stalls the input until it leaves. Config: load only.
module minimum_spanning_tree_cost_unit #(
  parameter int unsigned MAX_VERTICES = 16,
  parameter int unsigned MAX_EDGES    = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  mstc_pkg::in_t             in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output mstc_pkg::out_t            out_data_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [mstc_pkg::CFG_W-1:0] cfg_data_i
);
  import mstc_pkg::*;

  localparam int unsigned EIW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned FW  = $clog2(MAX_EDGES + 1);
  localparam int unsigned VW  = $clog2(MAX_VERTICES);
  localparam int unsigned NW  = $clog2(MAX_VERTICES + 1);
  localparam int unsigned CW  = (NW > CFG_W) ? NW : CFG_W;
  localparam int unsigned RW  = $clog2(VW + 1);
  localparam logic [CW-1:0] MaxV = CW'(MAX_VERTICES);
  localparam logic [VW-1:0] LastV = VW'(MAX_VERTICES - 1);
  localparam logic [FW-1:0] MaxE = FW'(MAX_EDGES);

  edge_t           ed_mem [MAX_EDGES];
  logic [VW-1:0]   par_mem [MAX_VERTICES];
  logic [RW-1:0]   rk_mem [MAX_VERTICES];

  state_e          state_q, state_d;
  logic [CFG_W-1:0] cfg_q;
  logic [FW-1:0]   fill_q, fill_d;
  logic            ovf_q, ovf_d;
  logic [VW-1:0]   clr_q, clr_d;
  logic [FW-1:0]   scan_q, scan_d;
  logic            pend_q, pend_d;
  logic [EIW-1:0]  pend_idx_q, pend_idx_d;
  logic            have_best_q, have_best_d;
  edge_t           best_q, best_d;
  logic [EIW-1:0]  best_idx_q, best_idx_d;
  logic            have_prev_q, have_prev_d;
  logic signed [15:0] prev_w_q, prev_w_d;
  logic [EIW-1:0]  prev_idx_q, prev_idx_d;
  logic [VW-1:0]   cur_q, cur_d;
  logic            fb_q, fb_d;
  logic [VW-1:0]   ra_q, ra_d;
  logic [VW-1:0]   rb_q, rb_d;
  logic [RW-1:0]   rka_q, rka_d;
  logic [NW-1:0]   taken_q, taken_d;
  logic [19:0]     cost_q, cost_d;
  logic            out_vld_q, out_vld_d;
  out_t            out_q, out_d;

  edge_t           ed_rd_q;
  logic [VW-1:0]   par_rd_q;
  logic [RW-1:0]   rk_rd_q;

  logic            ed_we;
  logic [EIW-1:0]  ed_wa, ed_ra;
  edge_t           ed_wd;
  logic            par_we, rk_we;
  logic [VW-1:0]   par_wa, par_wd, par_ra, rk_wa, rk_ra;
  logic [RW-1:0]   rk_wd;

  logic [CW-1:0]   n_eff;
  logic            in_acc;
  logic            is_after, is_before;
  logic            best_in_range;
  logic [CW-1:0]   taken_ext;

  assign cfg_ready_o = (state_q == S_LOAD);
  assign in_stall_o  = (state_q != S_LOAD);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;
  assign in_acc      = in_valid_i && (state_q == S_LOAD);

  always_comb begin
    if (cfg_q == '0) begin
      n_eff = CW'(1);
    end else if (CW'(cfg_q) > MaxV) begin
      n_eff = MaxV;
    end else begin
      n_eff = CW'(cfg_q);
    end
  end

  assign taken_ext = CW'(taken_q);
  assign best_in_range = (CW'(best_q.src) < n_eff) && (CW'(best_q.dst) < n_eff);

  assign is_after = !have_prev_q || (ed_rd_q.weight > prev_w_q) ||
                    ((ed_rd_q.weight == prev_w_q) && (pend_idx_q > prev_idx_q));
  assign is_before = !have_best_q || (ed_rd_q.weight < best_q.weight) ||
                     ((ed_rd_q.weight == best_q.weight) && (pend_idx_q < best_idx_q));

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    ovf_d       = ovf_q;
    clr_d       = clr_q;
    scan_d      = scan_q;
    pend_d      = pend_q;
    pend_idx_d  = pend_idx_q;
    have_best_d = have_best_q;
    best_d      = best_q;
    best_idx_d  = best_idx_q;
    have_prev_d = have_prev_q;
    prev_w_d    = prev_w_q;
    prev_idx_d  = prev_idx_q;
    cur_d       = cur_q;
    fb_d        = fb_q;
    ra_d        = ra_q;
    rb_d        = rb_q;
    rka_d       = rka_q;
    taken_d     = taken_q;
    cost_d      = cost_q;
    out_vld_d   = out_vld_q && out_stall_i;
    out_d       = out_q;
    ed_we       = 1'b0;
    ed_wa       = fill_q[EIW-1:0];
    ed_wd       = '{src: in_data_i.src_vertex, dst: in_data_i.dst_vertex,
                    weight: in_data_i.weight};
    ed_ra       = scan_q[EIW-1:0];
    par_we      = 1'b0;
    par_wa      = clr_q;
    par_wd      = clr_q;
    par_ra      = cur_q;
    rk_we       = 1'b0;
    rk_wa       = clr_q;
    rk_wd       = '0;
    rk_ra       = ra_q;

    unique case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          if ((CW'(in_data_i.src_vertex) < n_eff) && (CW'(in_data_i.dst_vertex) < n_eff)) begin
            if (fill_q < MaxE) begin
              ed_we  = 1'b1;
              fill_d = fill_q + FW'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end
          if (in_data_i.last_edge) begin
            clr_d   = '0;
            state_d = S_CLR;
          end
        end
      end
      S_CLR: begin
        par_we = 1'b1;
        rk_we  = 1'b1;
        clr_d  = clr_q + VW'(1);
        if (clr_q == LastV) begin
          taken_d     = '0;
          cost_d      = '0;
          have_prev_d = 1'b0;
          scan_d      = '0;
          pend_d      = 1'b0;
          have_best_d = 1'b0;
          state_d     = (n_eff > CW'(1)) ? S_SCAN : S_OUT;
        end
      end
      S_SCAN: begin
        if (pend_q && is_after && is_before) begin
          best_d      = ed_rd_q;
          best_idx_d  = pend_idx_q;
          have_best_d = 1'b1;
        end
        if (scan_q < fill_q) begin
          pend_d     = 1'b1;
          pend_idx_d = scan_q[EIW-1:0];
          scan_d     = scan_q + FW'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            state_d = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        if (!have_best_q) begin
          state_d = S_OUT;
        end else begin
          have_prev_d = 1'b1;
          prev_w_d    = best_q.weight;
          prev_idx_d  = best_idx_q;
          scan_d      = '0;
          pend_d      = 1'b0;
          have_best_d = 1'b0;
          if (best_in_range) begin
            cur_d   = VW'(best_q.src);
            fb_d    = 1'b0;
            state_d = S_FIND;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_FIND: begin
        state_d = S_FCHK;
      end
      S_FCHK: begin
        if (par_rd_q == cur_q) begin
          if (!fb_q) begin
            ra_d    = cur_q;
            cur_d   = VW'(best_q.dst);
            fb_d    = 1'b1;
            state_d = S_FIND;
          end else begin
            rb_d = cur_q;
            if (cur_q == ra_q) begin
              state_d = S_SCAN;
            end else begin
              state_d = S_RKA;
            end
          end
        end else begin
          cur_d   = par_rd_q;
          state_d = S_FIND;
        end
      end
      S_RKA: begin
        rk_ra   = ra_q;
        state_d = S_RKB;
      end
      S_RKB: begin
        rka_d   = rk_rd_q;
        rk_ra   = rb_q;
        state_d = S_JOIN;
      end
      S_JOIN: begin
        par_we = 1'b1;
        if (rka_q == rk_rd_q) begin
          par_wa = rb_q;
          par_wd = ra_q;
          rk_we  = 1'b1;
          rk_wa  = ra_q;
          rk_wd  = rka_q + RW'(1);
        end else if (rka_q > rk_rd_q) begin
          par_wa = rb_q;
          par_wd = ra_q;
        end else begin
          par_wa = ra_q;
          par_wd = rb_q;
        end
        taken_d = taken_q + NW'(1);
        cost_d  = cost_q + {{4{best_q.weight[15]}}, best_q.weight};
        state_d = ((taken_ext + CW'(2)) < n_eff) ? S_SCAN : S_OUT;
      end
      S_OUT: begin
        if (!out_vld_q || !out_stall_i) begin
          out_vld_d         = 1'b1;
          out_d.total_cost  = cost_q;
          out_d.edges_taken = 4'(taken_q);
          out_d.spanning    = ((taken_ext + CW'(1)) == n_eff);
          out_d.overflow    = ovf_q;
          fill_d            = '0;
          ovf_d             = 1'b0;
          state_d           = S_LOAD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ed_we) begin
      ed_mem[ed_wa] <= ed_wd;
    end
    ed_rd_q <= ed_mem[ed_ra];
    if (par_we) begin
      par_mem[par_wa] <= par_wd;
    end
    par_rd_q <= par_mem[par_ra];
    if (rk_we) begin
      rk_mem[rk_wa] <= rk_wd;
    end
    rk_rd_q <= rk_mem[rk_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_LOAD;
      cfg_q     <= CFG_RESET;
      fill_q    <= '0;
      ovf_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      ovf_q     <= ovf_d;
      out_vld_q <= out_vld_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    clr_q       <= clr_d;
    scan_q      <= scan_d;
    pend_q      <= pend_d;
    pend_idx_q  <= pend_idx_d;
    have_best_q <= have_best_d;
    best_q      <= best_d;
    best_idx_q  <= best_idx_d;
    have_prev_q <= have_prev_d;
    prev_w_q    <= prev_w_d;
    prev_idx_q  <= prev_idx_d;
    cur_q       <= cur_d;
    fb_q        <= fb_d;
    ra_q        <= ra_d;
    rb_q        <= rb_d;
    rka_q       <= rka_d;
    taken_q     <= taken_d;
    cost_q      <= cost_d;
    out_q       <= out_d;
  end

endmodule
